[rtl/core/compacting_handle_list_core_assert.svh]
// Assertion macros shared by the list core.
`ifndef COMPACTING_HANDLE_LIST_CORE_ASSERT_SVH
`define COMPACTING_HANDLE_LIST_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CHL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/chl_pkg.sv]
`default_nettype none
package chl_pkg;

    localparam int HandleW = 16;
    localparam int PosW    = 8;
    localparam int OpW     = 3;

    typedef enum logic [OpW-1:0] {
        OP_APPEND     = 3'd0,
        OP_REMOVE_AT  = 3'd1,
        OP_REMOVE_VAL = 3'd2,
        OP_READ       = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

    // Command broadcast to every cell along the chain.
    typedef struct packed {
        logic                fire;
        logic [OpW-1:0]      op;
        logic [HandleW-1:0]  handle;
        logic [PosW-1:0]     position;
    } cell_cmd_t;

endpackage
`default_nettype wire

[rtl/core/chl_cell.sv]
`default_nettype none
module chl_cell
    import chl_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5,
    parameter int IW  = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cell_cmd_t          cmd,
    input  wire logic [CW-1:0]      count,
    input  wire logic [IW-1:0]      rd_idx,
    input  wire logic [HandleW-1:0] next_entry,   // entry of cell IDX+1
    input  wire logic               shift_in,     // removal point lies left of this cell
    input  wire logic [HandleW-1:0] rd_in,
    output logic [HandleW-1:0]      entry,
    output logic                    shift_out,
    output logic [HandleW-1:0]      rd_out
);

    localparam logic [CW-1:0]   IdxC  = CW'(IDX);
    localparam logic [CW:0]     IdxP1 = (CW+1)'(IDX + 1);
    localparam logic [PosW-1:0] IdxP  = PosW'(IDX);
    localparam logic [IW-1:0]   IdxR  = IW'(IDX);

    logic [HandleW-1:0] entry_reg, entry_next;
    logic               live, next_live, kill, is_remove;

    always_comb begin
        live      = IdxC < count;
        next_live = IdxP1 < {1'b0, count};
        is_remove = (cmd.op == OP_REMOVE_AT) || (cmd.op == OP_REMOVE_VAL);
        kill      = live && (((cmd.op == OP_REMOVE_AT) && (cmd.position == IdxP)) ||
                             ((cmd.op == OP_REMOVE_VAL) && (entry_reg == cmd.handle)));
        shift_out = shift_in || kill;
        rd_out    = rd_in | ((rd_idx == IdxR) ? entry_reg : '0);

        entry_next = entry_reg;
        if (cmd.fire) begin
            if ((cmd.op == OP_APPEND) && (count == IdxC)) begin
                entry_next = cmd.handle;
            end else if (is_remove && shift_out && next_live) begin
                entry_next = next_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

[rtl/core/compacting_handle_list_core.sv]
`default_nettype none
// Compacting handle list: an ordered list of up to CAPACITY 16-bit handles, held in a
// row of cells, one entry per cell. Ops on s_tuser: append (fails when full),
// remove at index (out-of-range index ignored), remove first matching value, read
// with the index clamped into 0..count-1 (entry 0 on an empty list), and clear.
// Unused op codes leave the list alone and return ok = 0. Every transfer yields
// exactly one result carrying ok, the read handle (zero except for read) and the
// entry count after the op. For each op the command is broadcast to all
// cells, the removal point ripples along the row so later cells take their right
// neighbor's entry, and the result lands in the output register at the same edge
// that updates the list. A new transfer is taken every cycle while the result side
// keeps up; a stalled result holds off input. Reset zeroes all entries and the count.
`include "compacting_handle_list_core_assert.svh"
module compacting_handle_list_core
    import chl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [23:0]                       s_tdata,  // handle[15:0], position[23:16]
    input  wire logic [OpW-1:0]                    s_tuser,  // op
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // ok[0], read_handle[16:1], entry_count[16+CW:17], zero pad above
    output logic [((HandleW+1+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_tdata
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OutW  = ((HandleW + 1 + CW + 7) / 8) * 8;
    localparam int PadW  = OutW - (HandleW + 1 + CW);
    localparam logic [CW-1:0] CapC = CW'(CAPACITY);

    // ---- input unpack ----
    logic               fire;
    logic [HandleW-1:0] in_handle;
    logic [PosW-1:0]    in_pos;
    logic [OpW-1:0]     in_op;

    assign fire      = s_tvalid && s_tready;
    assign in_handle = s_tdata[HandleW-1:0];
    assign in_pos    = s_tdata[HandleW +: PosW];
    assign in_op     = s_tuser;

    // ---- state ----
    logic [CW-1:0]      count_reg, count_next;
    logic               out_valid_reg;
    logic               ok_reg, ok_next;
    logic [HandleW-1:0] rd_reg, rd_next;

    // Output register; input is taken whenever the held result leaves this cycle.
    assign s_tready = !out_valid_reg || m_tready;

    // ---- read index clamp: negative -> 0, past the tail -> count-1, empty -> 0 ----
    logic [IW-1:0] rd_idx;
    always_comb begin
        if (in_pos[PosW-1] || (count_reg == '0)) begin
            rd_idx = '0;
        end else if ({1'b0, in_pos[PosW-2:0]} >= PosW'(count_reg)) begin
            rd_idx = IW'(count_reg - 1'b1);
        end else begin
            rd_idx = in_pos[IW-1:0];
        end
    end

    // ---- cell row ----
    cell_cmd_t          cmd;
    logic [HandleW-1:0] entry_w [CAPACITY];
    logic               shift_w [CAPACITY+1];
    logic [HandleW-1:0] rd_w    [CAPACITY+1];

    // fire, op, handle, position from the top bit down
    assign cmd        = {fire, in_op, in_handle, in_pos};
    assign shift_w[0] = 1'b0;
    assign rd_w[0]    = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [HandleW-1:0] nbr;
        if (i == CAPACITY - 1) begin : g_tail
            assign nbr = '0;
        end else begin : g_body
            assign nbr = entry_w[i+1];
        end
        chl_cell #(
            .IDX (i),
            .CW  (CW),
            .IW  (IW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .count      (count_reg),
            .rd_idx     (rd_idx),
            .next_entry (nbr),
            .shift_in   (shift_w[i]),
            .rd_in      (rd_w[i]),
            .entry      (entry_w[i]),
            .shift_out  (shift_w[i+1]),
            .rd_out     (rd_w[i+1])
        );
    end

    // A removal hit anywhere shows up at the end of the chain.
    logic hit;
    assign hit = shift_w[CAPACITY];

    // ---- op decode: count and result ----
    always_comb begin
        count_next = count_reg;
        ok_next    = 1'b0;
        rd_next    = '0;
        unique case (in_op) inside
            OP_APPEND: begin
                if (count_reg < CapC) begin
                    count_next = count_reg + 1'b1;
                    ok_next    = 1'b1;
                end
            end
            OP_REMOVE_AT, OP_REMOVE_VAL: begin
                if (hit) begin
                    count_next = count_reg - 1'b1;
                    ok_next    = 1'b1;
                end
            end
            OP_READ: begin
                rd_next = rd_w[CAPACITY];
                ok_next = 1'b1;
            end
            OP_CLEAR: begin
                count_next = '0;
                ok_next    = 1'b1;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            ok_reg <= ok_next;
            rd_reg <= rd_next;
        end
    end

    // count_reg only moves with a new result, so it is the reported count.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PadW{1'b0}}, count_reg, rd_reg, ok_reg};

    // ---- checks ----
    `CHL_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CapC, "count beyond capacity")
    `CHL_ASSERT_NEXT(a_append_grow, fire && (in_op == OP_APPEND) && (count_reg < CapC),
        (count_reg == $past(count_reg) + 1'b1) && ok_reg, "append did not grow list")
    `CHL_ASSERT_NEXT(a_clear, fire && (in_op == OP_CLEAR),
        (count_reg == '0) && ok_reg, "clear did not empty list")
    `CHL_ASSERT_NEXT(a_rd_zero, fire && (in_op != OP_READ),
        rd_reg == '0, "read handle nonzero outside read")
    `CHL_ASSERT_NOW(a_hit_live, fire && hit, count_reg != '0, "removal hit on empty list")

endmodule
`default_nettype wire
